/* sv/tagged_key_set_table_top_defines.svh */
// Assertion macros used by the checker file of the tagged key set table.
`ifndef TAGGED_KEY_SET_TABLE_TOP_DEFINES_SVH
`define TAGGED_KEY_SET_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, idle while rst_n is low.
`define TKST_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkst assertion failed");

// Next-cycle implication, clocked on clk, idle while rst_n is low.
`define TKST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkst assertion failed");

`endif

/* sv/tkst_pkg.sv */
// Package: sizes, codes and controller/datapath interface types for the key set table.
package tkst_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int OP_W      = 2;
    localparam int KVAL_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int MCOUNT_W  = 5;

    localparam int IN_TDATA_W  = ((OP_W + KVAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + STATUS_W + MCOUNT_W + 7) / 8) * 8;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request, restart scan
        logic scan;    // examine one entry
        logic commit;  // apply update, load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // entry under scan is the last one
        logic out_hold;   // result register full and not taken
    } dp_stat_t;

endpackage

/* sv/tagged_key_set_table_top.sv */
// Top level of the tagged key set table: stream ports, controller and datapath.
//
// Request channel (s_*): one word per request. s_tdata carries the operation
// (lookup, insert if absent, delete) and the key value; s_tuser carries the
// key kind. Result channel (m_*): one word per request with the presence
// flag, a status code (done, no change, table full) and the member count.
// Each request scans every entry of the table once through a single compare
// unit, one entry per cycle, then commits its update and loads its result
// word; a new request is taken only once the previous one has committed.
// Lookups never change the table; inserts go into the lowest free entry.
// Reset empties the table (valid bits and member count cleared at once) and
// leaves the result register empty; no clearing pass is needed.
// The result sits in an output register: the next request is accepted and
// scanned while it waits, and only the commit of that request waits for
// m_tready, so a stalled receiver holds the block one word behind.
module tagged_key_set_table_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tkst_pkg::IN_TDATA_W-1:0]     s_tdata,   // operation[1:0], key_value[33:2]
    input  logic                                s_tuser,   // key_kind[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tkst_pkg::OUT_TDATA_W-1:0]    m_tdata    // was_present[0], status[2:1],
                                                           // member_count[7:3]
);

    tkst_pkg::dp_cmd_t  cmd;
    tkst_pkg::dp_stat_t stat;

    tkst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tkst_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (s_tdata[tkst_pkg::OP_W-1:0]),
        .key_value (s_tdata[tkst_pkg::OP_W +: tkst_pkg::KVAL_W]),
        .key_kind  (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

/* sv/tkst_ctrl.sv */
// Controller: sequences request capture, entry scan and commit.
module tkst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tkst_pkg::dp_stat_t stat,
    output tkst_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // wait for the previous result word to leave
                if (!stat.out_hold)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = ready_reg;

endmodule

/* sv/tkst_datapath.sv */
// Datapath: entry store, scan registers, member count and result register.
module tkst_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [tkst_pkg::OP_W-1:0]            operation,
    input  logic [tkst_pkg::KVAL_W-1:0]          key_value,
    input  logic                                 key_kind,
    input  tkst_pkg::dp_cmd_t                    cmd,
    output tkst_pkg::dp_stat_t                   stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tkst_pkg::OUT_TDATA_W-1:0]     out_data
);

    // entry store; valid bits are the only part cleared by reset
    tkst_pkg::key_t              value_mem [tkst_pkg::CAPACITY];
    logic                        kind_mem  [tkst_pkg::CAPACITY];
    logic [tkst_pkg::CAPACITY-1:0] valid_reg;

    logic [tkst_pkg::OP_W-1:0]   op_reg;
    tkst_pkg::key_t              key_reg;
    logic                        kind_reg;
    tkst_pkg::idx_t              idx_reg;
    logic                        hit_reg;
    tkst_pkg::idx_t              hit_idx_reg;
    logic                        free_reg;
    tkst_pkg::idx_t              free_idx_reg;
    tkst_pkg::cnt_t              total_reg;
    tkst_pkg::cnt_t              total_next;

    logic                        out_valid_reg;
    logic                        out_present_reg;
    tkst_pkg::status_t           out_status_reg;
    logic [tkst_pkg::MCOUNT_W-1:0] out_count_reg;

    logic                        match;
    logic                        wr_en;
    logic                        clr_en;
    tkst_pkg::status_t           status_next;

    assign match = valid_reg[idx_reg] && (kind_mem[idx_reg] == kind_reg)
                   && (value_mem[idx_reg] == key_reg);

    assign stat.scan_last = (idx_reg == tkst_pkg::IDX_W'(tkst_pkg::CAPACITY - 1));
    assign stat.out_hold  = out_valid_reg && !out_ready;

    // request capture and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (match)
            begin
                hit_reg <= 1'b1;
            end
            if (!valid_reg[idx_reg] && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            key_reg  <= tkst_pkg::key_t'(key_value);
            kind_reg <= key_kind;
        end
        if (cmd.scan)
        begin
            if (match)
            begin
                hit_idx_reg <= idx_reg;
            end
            // keep the lowest free slot
            if (!valid_reg[idx_reg] && !free_reg)
            begin
                free_idx_reg <= idx_reg;
            end
        end
    end

    // commit decision
    always_comb
    begin
        wr_en       = 1'b0;
        clr_en      = 1'b0;
        total_next  = total_reg;
        status_next = tkst_pkg::ST_DONE;
        case (op_reg)
            tkst_pkg::OP_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = tkst_pkg::ST_NO_CHANGE;
                end
                else if (!free_reg)
                begin
                    status_next = tkst_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    total_next = total_reg + 1'b1;
                end
            end
            tkst_pkg::OP_DELETE:
            begin
                if (hit_reg)
                begin
                    clr_en = 1'b1;
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - 1'b1;
                    end
                end
                else
                begin
                    status_next = tkst_pkg::ST_NO_CHANGE;
                end
            end
            default:
            begin
                status_next = tkst_pkg::ST_DONE;  // lookup, and the unused code
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            value_mem[free_idx_reg] <= key_reg;
            kind_mem[free_idx_reg]  <= kind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (wr_en)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
            total_reg <= total_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_present_reg <= hit_reg;
            out_status_reg  <= status_next;
            out_count_reg   <= tkst_pkg::MCOUNT_W'(total_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = tkst_pkg::OUT_TDATA_W'({out_count_reg, out_status_reg, out_present_reg});

endmodule

/* sv/tkst_checker.sv */
// Port-level checker for the tagged key set table, bound to the top level.
`include "tagged_key_set_table_top_defines.svh"

module tkst_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [tkst_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tkst_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // a stalled result word holds
    `TKST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one request at a time: ready drops after each accepted word
    `TKST_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // count never exceeds the table size
    `TKST_ASSERT_SAME(a_count_range, m_tvalid, m_tdata[7:3] <= 5'(tkst_pkg::CAPACITY))

    // a refused insert never reports the key as present
    `TKST_ASSERT_SAME(a_full_absent, m_tvalid && (m_tdata[2:1] == tkst_pkg::ST_FULL),
                      !m_tdata[0])

endmodule

bind tagged_key_set_table_top tkst_checker u_tkst_checker (.*);
